[rtl/quadratic_nearest_root_core_defines.svh]
// Assertion macros for the nearest-root core.
// Relies on the including module having i_clk and i_rst_n in scope.
`ifndef QUADRATIC_NEAREST_ROOT_CORE_DEFINES_SVH
`define QUADRATIC_NEAREST_ROOT_CORE_DEFINES_SVH

// Property checked on every rising edge outside reset
`define QNR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("nearest-root core assertion failed");

// Condition that must never hold outside reset
`define QNR_NEVER(lbl, cond) `QNR_ASSERT(lbl, !(cond))

`endif

[rtl/qnr_pkg.sv]
// Shared widths, constants and stage types for the nearest-root core.
// No dependencies.
`default_nettype none

package qnr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;              // coefficient / result width
    localparam int EPS_W     = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

    localparam int D_W   = 2 * CW + 2;          // discriminant magnitude
    localparam int S_W   = CW + 2;              // floor(sqrt(D))
    localparam int T_W   = 2 * S_W;             // square root trial width
    localparam int NUM_W = S_W + 2;             // signed -b +/- s
    localparam int NM_W  = NUM_W - 1;           // its magnitude
    localparam int N_W   = NM_W + FRAC_BITS;    // dividend
    localparam int DM_W  = CW + 1;              // |2a|
    localparam int Q_W   = CW - 1;              // quotient before sign bit
    localparam int CMP_W = DM_W + Q_W;          // divider compare width

    localparam logic [Q_W-1:0] Q_MAX = '1;
    // -1.0 in QX.F
    localparam logic [CW-1:0] NO_HIT_TIME = ~((CW'(1) << FRAC_BITS) - CW'(1));

    // Item data travelling alongside the square root
    typedef struct packed {
        logic                 vld;
        logic                 nohit;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
    } t_side;

    // Item control travelling alongside the divider
    typedef struct packed {
        logic vld;
        logic nohit;
    } t_tag;

endpackage

`default_nettype wire

[rtl/quadratic_nearest_root_core.sv]
// Nearest root above eps of a*t^2 + b*t + c in signed Q16.16, fully pipelined.
// Depends on qnr_pkg, qnr_disc, qnr_sqrt, qnr_div and the defines header.
//
// One item is taken in every cycle (busy is always low) and its result leaves
// on o_root_time / o_hit, marked by o_result_vld for exactly one cycle; the
// receiver cannot stall. The pipeline holds two discriminant stages, the
// 34-stage square root (one stage per result bit), a numerator stage, the
// 32-stage divider (overflow check plus one quotient bit per stage) and an
// output stage. eps is written through i_eps_we/i_eps_wdata and should only
// change while no item is in flight.
`include "quadratic_nearest_root_core_defines.svh"
`default_nettype none

module quadratic_nearest_root_core import qnr_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [CW-1:0] i_coef_a,
    input  wire logic signed [CW-1:0] i_coef_b,
    input  wire logic signed [CW-1:0] i_coef_c,
    input  wire logic                 i_eps_we,
    input  wire logic [EPS_W-1:0]     i_eps_wdata,
    output logic                      o_result_vld,
    output logic signed [CW-1:0]      o_root_time,
    output logic                      o_hit
);

    logic [EPS_W-1:0]    r_eps;
    t_side               w_dside;
    logic [D_W-1:0]      w_disc;
    t_side               w_sside;
    logic [S_W-1:0]      w_root;

    logic signed [NUM_W-1:0] n_bx, n_sx;
    logic signed [NUM_W-1:0] n_num [2];
    logic signed [DM_W-1:0]  n_ax;
    logic [1:0]              n_ok;
    logic [1:0][N_W-1:0]     n_n;
    logic [DM_W-1:0]         n_dm;

    t_tag                r_tag;
    logic [1:0]          r_ok;
    logic [1:0][N_W-1:0] r_n;
    logic [DM_W-1:0]     r_dm;

    t_tag                w_qtag;
    logic [1:0]          w_qok;
    logic [1:0][Q_W-1:0] w_q;
    logic [1:0]          n_v;
    logic [Q_W-1:0]      n_best;
    logic                n_hit;

    logic                r_vld;
    logic                r_hit;
    logic [CW-1:0]       r_time;

    assign busy = 1'b0;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_eps_we) begin
            r_eps <= i_eps_wdata;
        end
    end

    qnr_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_a     (i_coef_a),
        .i_b     (i_coef_b),
        .i_c     (i_coef_c),
        .o_side  (w_dside),
        .o_disc  (w_disc)
    );

    qnr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (w_dside),
        .i_disc  (w_disc),
        .o_side  (w_sside),
        .o_root  (w_root)
    );

    // Numerators -b +/- s, their magnitudes and the sign test against 2a
    always_comb begin
        n_bx     = NUM_W'(w_sside.b);
        n_sx     = $signed({2'b00, w_root});
        n_num[0] = -n_bx + n_sx;
        n_num[1] = -n_bx - n_sx;
        n_ax     = DM_W'(w_sside.a);
        n_dm     = DM_W'(n_ax[DM_W-1] ? -n_ax : n_ax) << 1;
        for (int l = 0; l < 2; l++) begin
            n_ok[l] = (n_num[l] != '0) && (n_num[l][NUM_W-1] == w_sside.a[CW-1]);
            n_n[l]  = N_W'(NM_W'(n_num[l][NUM_W-1] ? -n_num[l] : n_num[l])) << FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= '{vld: w_sside.vld, nohit: w_sside.nohit};
        end
        r_ok <= n_ok;
        r_n  <= n_n;
        r_dm <= n_dm;
    end

    qnr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag),
        .i_ok    (r_ok),
        .i_n     (r_n),
        .i_dm    (r_dm),
        .o_tag   (w_qtag),
        .o_ok    (w_qok),
        .o_q     (w_q)
    );

    // Pick the smaller root above eps; bubbles never flag a hit
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_v[l] = w_qok[l] && (w_q[l] > Q_W'(r_eps));
        end
        priority if (n_v[0] && n_v[1]) begin
            n_best = (w_q[0] < w_q[1]) ? w_q[0] : w_q[1];
        end else if (n_v[0]) begin
            n_best = w_q[0];
        end else begin
            n_best = w_q[1];
        end
        n_hit = w_qtag.vld && !w_qtag.nohit && (n_v[0] || n_v[1]);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_qtag.vld;
        end
        r_hit  <= n_hit;
        r_time <= n_hit ? CW'(n_best) : NO_HIT_TIME;
    end

    assign o_result_vld = r_vld;
    assign o_hit        = r_hit;
    assign o_root_time  = $signed(r_time);

    `QNR_ASSERT(a_hit_above_eps, o_result_vld && o_hit |-> !o_root_time[CW-1] && (o_root_time[CW-2:0] > (CW-1)'(r_eps)))
    `QNR_ASSERT(a_miss_value, o_result_vld && !o_hit |-> o_root_time == NO_HIT_TIME)
    `QNR_NEVER(a_hit_without_strobe, o_hit && !o_result_vld && $past(o_result_vld))

endmodule

`default_nettype wire

[rtl/qnr_disc.sv]
// Discriminant stages: b*b and a*c products, then D = b*b - 4ac.
// Depends on qnr_pkg.
`default_nettype none

module qnr_disc import qnr_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire logic signed [CW-1:0] i_a,
    input  wire logic signed [CW-1:0] i_b,
    input  wire logic signed [CW-1:0] i_c,
    output t_side                     o_side,
    output logic [D_W-1:0]            o_disc
);

    t_side                  r_s1;
    logic signed [2*CW-1:0] r_bb;
    logic signed [2*CW-1:0] r_ac;
    t_side                  r_s2;
    logic [D_W-1:0]         r_disc;
    logic signed [D_W:0]    n_d;

    // Products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= '{vld: i_vld, nohit: (i_a == '0), a: i_a, b: i_b};
        end
        r_bb <= i_b * i_b;
        r_ac <= i_a * i_c;
    end

    // Signed discriminant; negative means no hit
    assign n_d = (D_W+1)'(r_bb) - ((D_W+1)'(r_ac) <<< 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= '{vld: r_s1.vld, nohit: r_s1.nohit | n_d[D_W], a: r_s1.a, b: r_s1.b};
        end
        r_disc <= n_d[D_W] ? '0 : n_d[D_W-1:0];
    end

    assign o_side = r_s2;
    assign o_disc = r_disc;

endmodule

`default_nettype wire

[rtl/qnr_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on qnr_pkg.
`default_nettype none

module qnr_sqrt import qnr_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_side          i_side,
    input  wire logic [D_W-1:0] i_disc,
    output t_side               o_side,
    output logic [S_W-1:0]      o_root
);

    t_side          r_side [S_W];
    logic [D_W-1:0] r_rem  [S_W];
    logic [S_W-1:0] r_root [S_W];

    for (genvar k = 0; k < S_W; k++) begin : g_stage
        localparam int BIT = S_W - 1 - k;

        t_side          w_side;
        logic [D_W-1:0] w_rem;
        logic [S_W-1:0] w_root;
        logic [T_W-1:0] w_trial;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_side = i_side;
            assign w_rem  = i_disc;
            assign w_root = '0;
        end else begin : g_next
            assign w_side = r_side[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        // (r + 2^BIT)^2 - r^2 against the remaining D - r^2
        assign w_trial = (T_W'(w_root) << (BIT + 1)) | (T_W'(1) << (2 * BIT));
        assign w_ge    = T_W'(w_rem) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= w_side;
            end
            r_rem[k]  <= w_ge ? D_W'(T_W'(w_rem) - w_trial) : w_rem;
            r_root[k] <= w_root | (S_W'(w_ge) << BIT);
        end
    end

    assign o_side = r_side[S_W-1];
    assign o_root = r_root[S_W-1];

endmodule

`default_nettype wire

[rtl/qnr_div.sv]
// Two-lane pipelined restoring divider with saturation, one quotient bit per stage.
// Depends on qnr_pkg.
`default_nettype none

module qnr_div import qnr_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_tag                 i_tag,
    input  wire logic [1:0]           i_ok,
    input  wire logic [1:0][N_W-1:0]  i_n,
    input  wire logic [DM_W-1:0]      i_dm,
    output t_tag                      o_tag,
    output logic [1:0]                o_ok,
    output logic [1:0][Q_W-1:0]       o_q
);

    t_tag                r_tag [Q_W+1];
    logic [1:0]          r_ok  [Q_W+1];
    logic [1:0]          r_sat [Q_W+1];
    logic [DM_W-1:0]     r_dm  [Q_W+1];
    logic [1:0][N_W-1:0] r_rem [Q_W+1];
    logic [1:0][Q_W-1:0] r_q   [Q_W+1];
    logic [1:0]          n_sat;

    // Entry stage: quotient overflow check against |2a| * 2^Q_W
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_sat[l] = CMP_W'(i_n[l]) >= (CMP_W'(i_dm) << Q_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0] <= i_tag;
        end
        r_ok[0]  <= i_ok;
        r_sat[0] <= n_sat;
        r_dm[0]  <= i_dm;
        r_rem[0] <= i_n;
        r_q[0]   <= '0;
    end

    // Quotient bit steps
    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        localparam int BIT = Q_W - k;

        logic [CMP_W-1:0]    w_sub;
        logic [1:0]          w_ge;
        logic [1:0][N_W-1:0] w_rem;
        logic [1:0][Q_W-1:0] w_q;

        assign w_sub = CMP_W'(r_dm[k-1]) << BIT;

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                w_ge[l]  = CMP_W'(r_rem[k-1][l]) >= w_sub;
                w_rem[l] = w_ge[l] ? N_W'(CMP_W'(r_rem[k-1][l]) - w_sub) : r_rem[k-1][l];
                w_q[l]   = r_q[k-1][l] | (Q_W'(w_ge[l]) << BIT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else begin
                r_tag[k] <= r_tag[k-1];
            end
            r_ok[k]  <= r_ok[k-1];
            r_sat[k] <= r_sat[k-1];
            r_dm[k]  <= r_dm[k-1];
            r_rem[k] <= w_rem;
            r_q[k]   <= w_q;
        end
    end

    assign o_tag   = r_tag[Q_W];
    assign o_ok    = r_ok[Q_W];
    assign o_q[0]  = r_sat[Q_W][0] ? Q_MAX : r_q[Q_W][0];
    assign o_q[1]  = r_sat[Q_W][1] ? Q_MAX : r_q[Q_W][1];

endmodule

`default_nettype wire

[tb/sv/quadratic_nearest_root_core_test.sv]
// Self-checking bench for quadratic_nearest_root_core: directed table, then random items.
// Depends on qnr_pkg and the core RTL; results are predicted in the bench itself.
`default_nettype none

module quadratic_nearest_root_core_test;
    import qnr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] i_coef_a, i_coef_b, i_coef_c;
    logic                 i_eps_we;
    logic [EPS_W-1:0]     i_eps_wdata;
    logic                 o_result_vld;
    logic signed [CW-1:0] o_root_time;
    logic                 o_hit;

    quadratic_nearest_root_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_coef_a(i_coef_a), .i_coef_b(i_coef_b), .i_coef_c(i_coef_c),
        .i_eps_we(i_eps_we), .i_eps_wdata(i_eps_wdata),
        .o_result_vld(o_result_vld), .o_root_time(o_root_time), .o_hit(o_hit)
    );

    typedef struct packed {
        logic [CW-1:0] root_time;
        logic          hit;
    } t_hit_res;

    typedef struct {
        logic [CW-1:0] a, b, c;
        logic          known;   // expected result typed in
        t_hit_res      res;
    } t_row;

    localparam logic [CW-1:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] MINN = 32'h8000_0000;
    localparam logic [CW-1:0] ONE  = 32'h0001_0000;
    localparam int            LATENCY = 70;

    t_hit_res       expected_roots[$];
    logic [15:0]    eps_value;
    int             errors;
    int             n_results;
    int             n_hits;

    // Clock
    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Predicted nearest root for one set of coefficients
    function automatic t_hit_res nearest_root(logic signed [CW-1:0] a,
                                              logic signed [CW-1:0] b,
                                              logic signed [CW-1:0] c);
        logic signed [69:0]  disc;
        logic [69:0]         s;
        logic [69:0]         trial;
        logic signed [69:0]  num[2];
        logic signed [69:0]  den;
        logic [69:0]         q[2];
        logic [69:0]         best;
        logic                ok;
        t_hit_res            r;
        r.root_time = NO_HIT_TIME;
        r.hit       = 1'b0;
        if (a == 0) return r;
        disc = 70'(b) * 70'(b) - 70'sd4 * 70'(a) * 70'(c);
        if (disc < 0) return r;
        // bitwise floor square root
        s = '0;
        for (int k = 33; k >= 0; k--) begin
            trial = s | (70'd1 << k);
            if (trial * trial <= disc) s = trial;
        end
        num[0] = -70'(b) + $signed(s);
        num[1] = -70'(b) - $signed(s);
        den    = 70'sd2 * 70'(a);
        best   = '0;
        ok     = 1'b0;
        for (int k = 0; k < 2; k++) begin
            q[k] = '0;
            // only roots of the same sign as the denominator are positive
            if (num[k] != 0 && ((num[k] < 0) == (den < 0)))
                q[k] = ((num[k] < 0 ? -num[k] : num[k]) << FRAC_BITS) /
                       (den < 0 ? -den : den);
            if (q[k] > 70'(eps_value) && (!ok || q[k] < best)) begin
                best = q[k];
                ok   = 1'b1;
            end
        end
        if (ok) begin
            r.root_time = (best > 70'(MAXP)) ? MAXP : best[CW-1:0];
            r.hit       = 1'b1;
        end
        return r;
    endfunction

    // Result checker: every strobe is a transfer
    always @(posedge i_clk) begin
        t_hit_res want;
        if (i_rst_n && o_result_vld) begin
            n_results++;
            if (o_hit) n_hits++;
            if (expected_roots.size() == 0) begin
                $display("%0t: unexpected result root_time=%h hit=%b",
                         $time, o_root_time, o_hit);
                errors++;
            end else begin
                want = expected_roots.pop_front();
                if (o_root_time !== want.root_time) begin
                    $display("%0t: root_time expected %h actual %h",
                             $time, want.root_time, o_root_time);
                    errors++;
                end
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, o_hit);
                    errors++;
                end
            end
        end
    end

    // Random gap: mostly short, a few long; start only drops for a real gap
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // One input transfer; start held high across back-to-back items
    task automatic send_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
                              logic known, t_hit_res res);
        t_hit_res pred;
        pred = nearest_root(a, b, c);
        if (known && pred !== res)
            $display("%0t: table row disagrees with predictor", $time);
        start    <= 1'b1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_roots.push_back(known ? res : pred);
        if ($urandom_range(0, 2) != 0)
            idle_gap();
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_roots.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [15:0] v);
        i_eps_we    <= 1'b1;
        i_eps_wdata <= v;
        @(posedge i_clk);
        i_eps_we    <= 1'b0;
        eps_value    = v;
    endtask

    // Random coefficient of mixed scale
    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return CW'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: return CW'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            default: return CW'($signed($urandom_range(0, 511)) - 256);
        endcase
    endfunction

    // Coefficients built from two chosen roots so that real hits are common
    task automatic send_from_roots();
        logic signed [CW-1:0] r1, r2, a;
        logic signed [63:0]   b, c;
        r1 = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0002_0000;
        r2 = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0002_0000;
        a  = $signed($urandom_range(1, 32'h0004_0000));
        if ($urandom_range(0, 1)) a = -a;
        b  = -((64'(a) * (64'(r1) + 64'(r2))) >>> FRAC_BITS);
        c  = (((64'(a) * 64'(r1)) >>> FRAC_BITS) * 64'(r2)) >>> FRAC_BITS;
        send_coefs(a, b[CW-1:0], c[CW-1:0], 1'b0, '0);
    endtask

    t_row table_rows[$];

    task automatic add_row(logic [CW-1:0] a, b, c, logic known = 1'b0,
                           logic [CW-1:0] t = NO_HIT_TIME, logic h = 1'b0);
        t_row r;
        r.a = a; r.b = b; r.c = c; r.known = known;
        r.res.root_time = t; r.res.hit = h;
        table_rows.push_back(r);
    endtask

    initial begin
        int items;
        errors = 0; n_results = 0; n_hits = 0;
        eps_value = EPS_RESET;
        i_rst_n = 1'b0; start = 1'b0; i_eps_we = 1'b0; i_eps_wdata = '0;
        i_coef_a = '0; i_coef_b = '0; i_coef_c = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        add_row('0, ONE, ONE, 1'b1);                     // a zero
        add_row('0, '0, '0, 1'b1);                       // all zero
        add_row(ONE, '0, ONE, 1'b1);                     // negative discriminant
        add_row(ONE, 32'hFFFD_0000, 32'h0002_0000, 1'b1, ONE, 1'b1); // roots 1, 2
        add_row(ONE, 32'h0003_0000, 32'h0002_0000, 1'b1);            // roots -1, -2
        add_row(ONE, 32'hFFFE_0000, ONE, 1'b1, ONE, 1'b1);           // double root 1
        add_row(ONE, 32'hFFFF_0000, '0, 1'b1, ONE, 1'b1);            // roots 0, 1
        add_row(ONE, '0, '0, 1'b1);                                  // zero root only
        add_row(32'h0000_0001, MINN, '0, 1'b1, MAXP, 1'b1);          // saturation
        add_row(32'h0000_0001, 32'hFFFF_FF00, '0);
        add_row(MAXP, MAXP, MAXP);
        add_row(MINN, MINN, MINN);
        add_row(MINN, MAXP, MINN);
        add_row(MAXP, MINN, MINN);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(ONE, '0, 32'hFFFF_0000);                             // roots +/-1
        add_row(32'hFFFF_0000, ONE, 32'h0000_0020);                  // tiny negative root, other root near 1
        add_row(ONE, 32'hFFFF_FFFF, '0);
        add_row(32'h0000_0001, 32'h0000_0001, MAXP);
        foreach (table_rows[i])
            send_coefs(table_rows[i].a, table_rows[i].b, table_rows[i].c,
                       table_rows[i].known, table_rows[i].res);
        drain();

        // Random phases over several eps settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_eps(16'h0000);
                1: write_eps(16'hFFFF);
                2: write_eps(16'(EPS_RESET));
                default: write_eps(16'($urandom_range(0, 65535)));
            endcase
            items = 0;
            while (items < 90) begin
                if ($urandom_range(0, 9) < 6) send_from_roots();
                else send_coefs(rand_coef(), rand_coef(), rand_coef(), 1'b0, '0);
                items++;
            end
            drain();
        end

        $display("Covered %0d results (%0d hits) over directed cases and 5 eps settings.",
                 n_results, n_hits);
        if (errors == 0 && expected_roots.size() == 0) begin
            $display("[quadratic_nearest_root_core] OK");
        end else begin
            $display("[quadratic_nearest_root_core] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("[quadratic_nearest_root_core] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
